// ===== rtl/uet_pkg.sv =====
// Shared types and constants of the undirected edge table.
package uet_pkg;

  localparam int WEIGHT_W = 16;
  localparam int TAG_W    = 6;

  // Operation codes carried on the func field.
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;
  localparam logic [1:0] FUNC_MODIFY = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_ARG   = 2'd3;

  typedef logic [1:0] rd_sel_t;

  // Read address sources of the table memory.
  localparam rd_sel_t RD_ZERO = 2'd0;
  localparam rd_sel_t RD_NEXT = 2'd1;
  localparam rd_sel_t RD_LAST = 2'd2;
  localparam rd_sel_t RD_POS  = 2'd3;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_src;
    logic    scan_start;
    logic    scan_step;
    logic    capture;
    logic    finish;
  } uet_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       count_zero;
    logic       scan_match;
    logic       scan_last;
    logic       out_free;
  } uet_sts_t;

endpackage

// ===== rtl/undirected_edge_table_top.sv =====
// Top level of the undirected edge table: sequencer, datapath and checks.
//
// The block keeps up to TABLE_DEPTH undirected weighted edges in a single-port-write,
// registered-read memory and runs one operation at a time, giving one result for each
// transaction taken on the input. Add and modify need no scan; lookup and delete compare
// one stored entry per cycle through the memory read port, from position 0 until the
// first match, or through the entry count when there is none. The result is held in an
// output register, so a new transaction is taken while an earlier result still waits;
// the block only stalls completion until that register is free. No clearing pass is
// needed after reset: only entries below the count are ever used in a result or
// written back.
module undirected_edge_table_top #(
  parameter int TABLE_DEPTH = 64,
  parameter int NODE_BITS   = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_func,
  input  logic [NODE_BITS-1:0]               in_node_a,
  input  logic [NODE_BITS-1:0]               in_node_b,
  input  logic [uet_pkg::WEIGHT_W-1:0]       in_weight,
  input  logic [$clog2(TABLE_DEPTH)-1:0]     in_position,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic [$clog2(TABLE_DEPTH)-1:0]     out_hit_position,
  output logic [uet_pkg::WEIGHT_W-1:0]       out_hit_weight,
  output logic [uet_pkg::TAG_W-1:0]          out_hit_tag,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]   out_entry_count
);
  import uet_pkg::*;

  localparam int POS_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  uet_cmd_t cmd;
  uet_sts_t sts;

  uet_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  uet_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NODE_BITS   (NODE_BITS),
    .POS_W       (POS_W),
    .CNT_W       (CNT_W)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_func          (in_func),
    .in_node_a        (in_node_a),
    .in_node_b        (in_node_b),
    .in_weight        (in_weight),
    .in_position      (in_position),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_hit_position (out_hit_position),
    .out_hit_weight   (out_hit_weight),
    .out_hit_tag      (out_hit_tag),
    .out_entry_count  (out_entry_count)
  );

`ifndef ASSERT_OFF
  // Once a transaction is taken, the input is stalled in the cycle after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again while an operation was in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= CNT_W'(TABLE_DEPTH)))
    else $error("entry count beyond table depth");

  // A failed operation reports no position, weight or tag.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      ((out_hit_position == '0) && (out_hit_weight == '0) && (out_hit_tag == '0)))
    else $error("failed operation carries result fields");

  a_sts_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_entry_count == CNT_W'(TABLE_DEPTH)))
    else $error("table reported full below its depth");
`endif

endmodule

// ===== rtl/uet_ctrl.sv =====
// Sequencer of the edge table: decode, linear scan and completion of one operation.
module uet_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  uet_pkg::uet_sts_t sts,
  output uet_pkg::uet_cmd_t cmd
);
  import uet_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.func)
          FUNC_ADD: begin
            state_nxt = S_FINISH;
          end
          FUNC_MODIFY: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = RD_POS;
            state_nxt  = S_FINISH;
          end
          FUNC_LOOKUP, FUNC_DELETE: begin
            if (sts.count_zero) begin
              state_nxt = S_FINISH;
            end else begin
              cmd.rd_en      = 1'b1;
              cmd.rd_src     = RD_ZERO;
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (sts.scan_match) begin
          cmd.capture = 1'b1;
          // A delete needs the last entry to fill the hole it leaves.
          if (sts.func == FUNC_DELETE) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = RD_LAST;
          end
          state_nxt = S_FINISH;
        end else if (sts.scan_last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_src    = RD_NEXT;
          cmd.scan_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/uet_dp.sv =====
// Datapath of the edge table: entry memory, count, scan compare and result register.
module uet_dp #(
  parameter int TABLE_DEPTH = 64,
  parameter int NODE_BITS   = 8,
  parameter int POS_W       = 6,
  parameter int CNT_W       = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   in_func,
  input  logic [NODE_BITS-1:0]         in_node_a,
  input  logic [NODE_BITS-1:0]         in_node_b,
  input  logic [uet_pkg::WEIGHT_W-1:0] in_weight,
  input  logic [POS_W-1:0]             in_position,
  input  uet_pkg::uet_cmd_t            cmd,
  output uet_pkg::uet_sts_t            sts,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic [POS_W-1:0]             out_hit_position,
  output logic [uet_pkg::WEIGHT_W-1:0] out_hit_weight,
  output logic [uet_pkg::TAG_W-1:0]    out_hit_tag,
  output logic [CNT_W-1:0]             out_entry_count
);
  import uet_pkg::*;

  typedef struct packed {
    logic [NODE_BITS-1:0] node_from;
    logic [NODE_BITS-1:0] node_to;
    logic [WEIGHT_W-1:0]  weight;
    logic [TAG_W-1:0]     tag;
  } entry_t;

  entry_t edge_mem [TABLE_DEPTH];
  entry_t rd_data_r;

  // Latched operation.
  logic [1:0]           func_r;
  logic [NODE_BITS-1:0] node_a_r;
  logic [NODE_BITS-1:0] node_b_r;
  logic [WEIGHT_W-1:0]  weight_r;
  logic [POS_W-1:0]     pos_r;

  logic [CNT_W-1:0]     count_r;
  logic [POS_W-1:0]     cmp_idx_r;
  logic                 found_r;
  logic [POS_W-1:0]     found_idx_r;
  logic [TAG_W-1:0]     found_tag_r;
  logic [WEIGHT_W-1:0]  found_w_r;

  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [POS_W-1:0]     out_pos_r;
  logic [WEIGHT_W-1:0]  out_w_r;
  logic [TAG_W-1:0]     out_tag_r;
  logic [CNT_W-1:0]     out_count_r;

  logic [POS_W-1:0]     last_idx;
  logic [POS_W-1:0]     rd_addr;
  logic                 full;
  logic                 mod_bad;
  logic                 match;
  logic                 out_free;

  logic [1:0]           res_status;
  logic [POS_W-1:0]     res_pos;
  logic [WEIGHT_W-1:0]  res_w;
  logic [TAG_W-1:0]     res_tag;
  logic [CNT_W-1:0]     count_nxt;
  logic                 wr_en;
  logic [POS_W-1:0]     wr_addr;
  entry_t               wr_data;

  assign last_idx = POS_W'(count_r - 1'b1);
  assign full     = (count_r == CNT_W'(TABLE_DEPTH));
  assign mod_bad  = (CNT_W'(pos_r) >= count_r) || (weight_r == '0);
  assign match    = ((rd_data_r.node_from == node_a_r) && (rd_data_r.node_to == node_b_r)) ||
                    ((rd_data_r.node_from == node_b_r) && (rd_data_r.node_to == node_a_r));
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    sts            = '0;
    sts.func       = func_r;
    sts.count_zero = (count_r == '0);
    sts.scan_match = match;
    sts.scan_last  = (cmp_idx_r == last_idx);
    sts.out_free   = out_free;
  end

  always_comb begin
    unique case (cmd.rd_src)
      RD_ZERO: rd_addr = '0;
      RD_NEXT: rd_addr = POS_W'(cmp_idx_r + 1'b1);
      RD_LAST: rd_addr = last_idx;
      RD_POS:  rd_addr = pos_r;
    endcase
  end

  // Result and table update for the completing operation.
  always_comb begin
    res_status = ST_OK;
    res_pos    = '0;
    res_w      = '0;
    res_tag    = '0;
    count_nxt  = count_r;
    wr_en      = 1'b0;
    wr_addr    = pos_r;
    wr_data    = rd_data_r;
    unique case (func_r)
      FUNC_ADD: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          res_pos   = count_r[POS_W-1:0];
          res_tag   = TAG_W'(count_r);
          wr_en     = 1'b1;
          wr_addr   = count_r[POS_W-1:0];
          wr_data   = '{node_from: node_a_r, node_to: node_b_r,
                        weight: weight_r, tag: TAG_W'(count_r)};
          count_nxt = count_r + 1'b1;
        end
      end
      FUNC_DELETE: begin
        if (!found_r) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_pos   = found_idx_r;
          res_tag   = found_tag_r;
          wr_en     = 1'b1;
          wr_addr   = found_idx_r;
          wr_data   = rd_data_r;
          count_nxt = count_r - 1'b1;
        end
      end
      FUNC_LOOKUP: begin
        if (!found_r) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_pos = found_idx_r;
          res_w   = found_w_r;
          res_tag = found_tag_r;
        end
      end
      FUNC_MODIFY: begin
        if (mod_bad) begin
          res_status = ST_BAD_ARG;
        end else begin
          res_pos        = pos_r;
          res_tag        = rd_data_r.tag;
          wr_en          = 1'b1;
          wr_addr        = pos_r;
          wr_data        = rd_data_r;
          wr_data.weight = weight_r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && wr_en) begin
      edge_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= edge_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        found_r <= 1'b0;
      end else if (cmd.capture) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      node_a_r <= in_node_a;
      node_b_r <= in_node_b;
      weight_r <= in_weight;
      pos_r    <= in_position;
    end
    if (cmd.scan_start) begin
      cmp_idx_r <= '0;
    end else if (cmd.scan_step) begin
      cmp_idx_r <= POS_W'(cmp_idx_r + 1'b1);
    end
    if (cmd.capture) begin
      found_idx_r <= cmp_idx_r;
      found_tag_r <= rd_data_r.tag;
      found_w_r   <= rd_data_r.weight;
    end
    if (cmd.finish) begin
      out_status_r <= res_status;
      out_pos_r    <= res_pos;
      out_w_r      <= res_w;
      out_tag_r    <= res_tag;
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_hit_position = out_pos_r;
  assign out_hit_weight   = out_w_r;
  assign out_hit_tag      = out_tag_r;
  assign out_entry_count  = out_count_r;

endmodule
